>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is high.
`define DSCW_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Concurrent check that also holds while reset is high.
`define DSCW_ASSERT_RST(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

>>> sv/dscw_pkg.sv
`timescale 1ns / 1ps

package dscw_pkg;

   // Sample width of both channels.
   localparam int SAMPLE_BITS = 24;
   // Fraction bits of every internal magnitude.
   localparam int FB = 30;
   // Shift from the input format to Q.30 and from Q.30 to the output format.
   localparam int ISH = FB + 1 - SAMPLE_BITS;
   localparam int OSH = FB + 2 - SAMPLE_BITS;
   localparam logic [32:0] ROUND_O = (OSH > 0) ? (33'd1 << (OSH - 1)) : 33'd0;

   localparam logic [63:0] ONE_Q  = 64'd1 << FB;
   localparam logic [63:0] HALF_Q = 64'd1 << (FB - 1);
   localparam logic [63:0] C_0P7  = 64'd751619277;
   localparam logic [63:0] C_0P9  = 64'd966367642;
   localparam logic [63:0] C_0P1  = 64'd107374182;

   localparam logic [9:0] INTENSITY_MAX   = 10'd1000;
   localparam logic [9:0] INTENSITY_RESET = 10'd500;

   // Register map, indexed by word address.
   localparam int CSR_ADDR_BITS = 3;
   localparam logic [0:0] REG_INTENSITY = 1'b0;

   // Pipeline positions of the back end.
   localparam int LOG_STEPS = 30;
   localparam int EXP_STEPS = 30;
   localparam int ST_W      = 2;
   localparam int ST_X      = 3;
   localparam int ST_U      = 4;
   localparam int ST_LOG0   = 5;
   localparam int ST_P      = ST_LOG0 + LOG_STEPS;
   localparam int ST_EXP0   = ST_P + 1;
   localparam int ST_G      = ST_EXP0 + EXP_STEPS;
   localparam int ST_Y      = ST_G + 1;
   localparam int ST_Y2     = ST_Y + 1;
   localparam int ST_Y3     = ST_Y2 + 1;
   localparam int ST_WS     = ST_Y3 + 1;
   localparam int ST_M      = ST_WS + 1;
   localparam int NST       = ST_M + 1;

   typedef struct packed {
      logic                   neg;
      logic                   byp;
      logic [SAMPLE_BITS-2:0] byp_mag;
      logic [30:0]            a30;
      logic [9:0]             t;
   } front_item_type;

   typedef struct packed {
      logic                   neg;
      logic                   byp;
      logic [SAMPLE_BITS-2:0] byp_mag;
      logic [30:0]            a30;
      logic [30:0]            w;
   } back_ctx_type;

   // Entry k of the exp2 table: 2^(2^-k) in Q.30, built by repeated integer
   // square roots starting from 2.0.
   function automatic logic [31:0] exp_tab_f(input int k);
      logic [63:0] tv;
      logic [63:0] n;
      logic [63:0] r;
      logic [63:0] b;
      tv = 64'd2 << FB;
      for (int j = 1; j <= k; j++) begin
         n = tv << FB;
         r = 64'd0;
         b = 64'd1 << 62;
         for (int i = 0; i < 32; i++) begin
            if (n >= r + b) begin
               n = n - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         tv = r;
      end
      return tv[31:0];
   endfunction

endpackage

>>> sv/dscw_if.sv
`timescale 1ns / 1ps

interface dscw_req_if import dscw_pkg::*;;
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_in;
   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

interface dscw_rsp_if import dscw_pkg::*;;
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_out;
   modport source (output valid, output sample_out, input ready);
   modport sink (input valid, input sample_out, output ready);
endinterface

>>> sv/dscw_front.sv
`timescale 1ns / 1ps

module dscw_front import dscw_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [SAMPLE_BITS-1:0] in_sample,
   input  logic [9:0]                    intensity,
   output logic                          out_valid,
   output front_item_type                out_item,
   input  logic                          out_ready
);

   logic                   valid_ff, valid_in;
   front_item_type         item_ff, item_in;
   logic                   take;
   logic                   neg;
   logic [SAMPLE_BITS-1:0] mag;
   logic [30:0]            a30;
   logic [9:0]             tc;

   assign in_ready  = !valid_ff || out_ready;
   assign take      = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   // Magnitude of the sample; the most negative code maps to 2^(N-1).
   assign neg = in_sample[SAMPLE_BITS-1];
   assign mag = neg ? (~in_sample + 1'b1) : in_sample;

   if (ISH >= 0) begin : g_widen
      assign a30 = 31'(31'(mag) << ISH);
   end else begin : g_narrow
      assign a30 = 31'((33'(mag) + (33'd1 << (-ISH - 1))) >> (-ISH));
   end

   assign tc = (intensity > INTENSITY_MAX) ? INTENSITY_MAX : intensity;

   always_comb begin
      item_in.neg     = neg;
      item_in.byp     = (tc == 10'd0);
      item_in.byp_mag = (SAMPLE_BITS - 1)'((SAMPLE_BITS + 1)'(mag) + 1'b1 >> 1);
      item_in.a30     = a30;
      item_in.t       = tc;
   end

   assign valid_in = take || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

endmodule

>>> sv/dscw_queue.sv
`timescale 1ns / 1ps

module dscw_queue import dscw_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   output logic           push_ready,
   input  front_item_type push_item,
   output logic           pop_valid,
   input  logic           pop,
   output front_item_type pop_item
);

   front_item_type mem_ff [4];
   logic [1:0]     wr_ptr_ff, wr_ptr_in;
   logic [1:0]     rd_ptr_ff, rd_ptr_in;
   logic [2:0]     count_ff, count_in;
   logic           do_push, do_pop;

   assign push_ready = (count_ff != 3'd4);
   assign pop_valid  = (count_ff != 3'd0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   assign wr_ptr_in = wr_ptr_ff + 2'(do_push);
   assign rd_ptr_in = rd_ptr_ff + 2'(do_pop);
   assign count_in  = count_ff + 3'(do_push) - 3'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> sv/dscw_back.sv
`timescale 1ns / 1ps

module dscw_back import dscw_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  front_item_type                in_item,
   output logic                          in_pop,
   output logic                          out_valid,
   output logic signed [SAMPLE_BITS-1:0] out_sample,
   input  logic                          out_ready
);

   logic                   adv;
   logic [NST-1:0]         vld_ff, vld_in;
   back_ctx_type           ctx_ff [NST];
   back_ctx_type           ctx_in [NST];
   back_ctx_type           ctx0, ctx_w;
   logic [32:0]            xc_ff [NST];
   logic [32:0]            xc_in [NST];
   logic [32:0]            x_calc;

   logic [19:0]            v1_ff, v1_in, v2_ff;
   logic [29:0]            wi1_ff, wi1_in, wi2_ff;
   logic [9:0]             q0_ff, q0_in;
   logic [20:0]            rem;
   logic [30:0]            w_calc;
   logic [32:0]            drive;

   logic [33:0]            u;
   logic [1:0]             e_in, e_ff;
   logic [30:0]            m_in, m_ff;

   logic [30:0]            lm_ff [LOG_STEPS];
   logic [30:0]            lm_in [LOG_STEPS];
   logic [29:0]            lf_ff [LOG_STEPS];
   logic [29:0]            lf_in [LOG_STEPS];
   logic [1:0]             le_ff [LOG_STEPS];
   logic [1:0]             le_in [LOG_STEPS];

   logic [31:0]            p_calc;
   logic [1:0]             n_ff, n_in;
   logic [30:0]            vx_ff, vx_in;
   logic                   one_ff, one_in;

   logic [31:0]            ee_ff [EXP_STEPS];
   logic [31:0]            ee_in [EXP_STEPS];
   logic [30:0]            ev_ff [EXP_STEPS];
   logic [30:0]            ev_in [EXP_STEPS];
   logic [1:0]             en_ff [EXP_STEPS];
   logic [1:0]             en_in [EXP_STEPS];
   logic                   eo_ff [EXP_STEPS];
   logic                   eo_in [EXP_STEPS];

   logic [31:0]            ef;
   logic [30:0]            g_ff, g_in;
   logic [30:0]            y_ff, y_in, yb_ff, yc_ff;
   logic [31:0]            y2_ff, y2_in;
   logic [31:0]            y3_ff, y3_in;
   logic [30:0]            ws_ff, ws_in;
   logic [31:0]            mm_ff, mm_in;

   logic                   ov_ff;
   logic [SAMPLE_BITS-1:0] os_ff, os_in;
   logic [SAMPLE_BITS-1:0] omag;

   // The whole pipeline moves together whenever the output register can move.
   assign adv       = !ov_ff || out_ready;
   assign in_pop    = adv && in_valid;
   assign out_valid = ov_ff;
   assign out_sample = os_ff;

   assign vld_in = {vld_ff[NST-2:0], in_valid};

   // Context that rides along with every item.
   always_comb begin
      ctx0.neg     = in_item.neg;
      ctx0.byp     = in_item.byp;
      ctx0.byp_mag = in_item.byp_mag;
      ctx0.a30     = in_item.a30;
      ctx0.w       = 31'd0;
      ctx_w        = ctx_ff[ST_W - 1];
      ctx_w.w      = w_calc;
   end

   for (genvar i = 0; i < NST; i++) begin : g_carry
      if (i == 0) begin : g_first
         assign ctx_in[i] = ctx0;
         assign xc_in[i]  = 33'd0;
      end else begin : g_rest
         assign ctx_in[i] = (i == ST_W) ? ctx_w : ctx_ff[i-1];
         assign xc_in[i]  = (i == ST_X) ? x_calc : xc_ff[i-1];
      end
   end

   // Mix weight w = round(t * 2^30 / 1000), split as t*1073741 plus
   // floor((t*824 + 500) / 1000); the small quotient uses a reciprocal
   // estimate that is low by at most one, fixed by one compare.
   assign v1_in  = 20'(32'(in_item.t) * 32'd824 + 32'd500);
   assign wi1_in = 30'(30'(in_item.t) * 30'd1073741);
   assign q0_in  = 10'((40'(v1_ff) * 40'd1048) >> 20);
   assign rem    = 21'(v2_ff) - 21'(21'(q0_ff) * 21'd1000);
   assign w_calc = 31'(wi2_ff) + 31'(q0_ff) + 31'(rem >= 21'd1000);

   // Driven input x = a * (1 + 4w).
   assign drive  = 33'(ONE_Q) + {ctx_ff[ST_X-1].w, 2'b00};
   assign x_calc = 33'((64'(ctx_ff[ST_X-1].a30) * 64'(drive) + HALF_Q) >> FB);

   // Integer part of log2(1 + x) and the mantissa in [1, 2).
   always_comb begin
      u = 34'(xc_ff[ST_U-1]) + 34'(ONE_Q);
      if (u >= 34'(ONE_Q << 2)) begin
         e_in = 2'd2;
      end else if (u >= 34'(ONE_Q << 1)) begin
         e_in = 2'd1;
      end else begin
         e_in = 2'd0;
      end
      m_in = 31'(u >> e_in);
   end

   // One squaring per stage yields one fraction bit of the logarithm.
   for (genvar k = 0; k < LOG_STEPS; k++) begin : g_log
      logic [30:0] pm;
      logic [29:0] pf;
      logic [1:0]  pe;
      logic [31:0] sq;
      if (k == 0) begin : g_first
         assign pm = m_ff;
         assign pf = 30'd0;
         assign pe = e_ff;
      end else begin : g_rest
         assign pm = lm_ff[k-1];
         assign pf = lf_ff[k-1];
         assign pe = le_ff[k-1];
      end
      assign sq       = 32'((62'(pm) * 62'(pm)) >> FB);
      assign lm_in[k] = sq[31] ? sq[31:1] : sq[30:0];
      assign lf_in[k] = {pf[28:0], sq[31]};
      assign le_in[k] = pe;
   end

   // p = 0.7 * log2(1 + x), split into integer n and fraction r.
   assign p_calc = 32'((64'({le_ff[LOG_STEPS-1], lf_ff[LOG_STEPS-1]}) * C_0P7 + HALF_Q)
                       >> FB);
   assign n_in   = p_calc[31:30];
   assign vx_in  = 31'(ONE_Q) - 31'(p_calc[29:0]);
   assign one_in = (p_calc[29:0] == 30'd0);

   // 2^(1 - r): one table multiply per stage for each set bit.
   for (genvar j = 0; j < EXP_STEPS; j++) begin : g_exp
      localparam logic [31:0] TAB = exp_tab_f(j + 1);
      logic [31:0] pe;
      logic [30:0] pv;
      logic [1:0]  pn;
      logic        po;
      if (j == 0) begin : g_first
         assign pe = 32'(ONE_Q);
         assign pv = vx_ff;
         assign pn = n_ff;
         assign po = one_ff;
      end else begin : g_rest
         assign pe = ee_ff[j-1];
         assign pv = ev_ff[j-1];
         assign pn = en_ff[j-1];
         assign po = eo_ff[j-1];
      end
      assign ee_in[j] = pv[FB-1-j] ? 32'((64'(pe) * 64'(TAB) + HALF_Q) >> FB) : pe;
      assign ev_in[j] = pv;
      assign en_in[j] = pn;
      assign eo_in[j] = po;
   end

   // Gain 2^-p and the wet path. The square and the cube of y can exceed
   // 2.0, so they carry one more integer bit than y.
   assign ef    = eo_ff[EXP_STEPS-1] ? 32'(ONE_Q << 1) : ee_ff[EXP_STEPS-1];
   assign g_in  = 31'((33'(ef) + (33'd1 << en_ff[EXP_STEPS-1])) >> (en_ff[EXP_STEPS-1] + 2'd1));
   assign y_in  = 31'((64'(xc_ff[ST_Y-1]) * 64'(g_ff) + HALF_Q) >> FB);
   assign y2_in = 32'((64'(y_ff) * 64'(y_ff) + HALF_Q) >> FB);
   assign y3_in = 32'((64'(y2_ff) * 64'(yb_ff) + HALF_Q) >> FB);
   assign ws_in = 31'((64'(yc_ff) * C_0P9 + 64'(y3_ff) * C_0P1 + HALF_Q) >> FB);
   assign mm_in = 32'(((ONE_Q - 64'(ctx_ff[ST_M-1].w)) * 64'(ctx_ff[ST_M-1].a30)
                       + 64'(ctx_ff[ST_M-1].w) * 64'(ws_ff) + HALF_Q) >> FB);

   // Output format conversion, bypass and sign.
   always_comb begin
      if (ctx_ff[NST-1].byp) begin
         omag = SAMPLE_BITS'(ctx_ff[NST-1].byp_mag);
      end else begin
         omag = SAMPLE_BITS'((33'(mm_ff) + ROUND_O) >> OSH);
      end
      os_in = ctx_ff[NST-1].neg ? (~omag + 1'b1) : omag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         ov_ff  <= 1'b0;
      end else if (adv) begin
         vld_ff <= vld_in;
         ov_ff  <= vld_ff[NST-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctx_ff <= ctx_in;
         xc_ff  <= xc_in;
         v1_ff  <= v1_in;
         wi1_ff <= wi1_in;
         v2_ff  <= v1_ff;
         wi2_ff <= wi1_ff;
         q0_ff  <= q0_in;
         e_ff   <= e_in;
         m_ff   <= m_in;
         lm_ff  <= lm_in;
         lf_ff  <= lf_in;
         le_ff  <= le_in;
         n_ff   <= n_in;
         vx_ff  <= vx_in;
         one_ff <= one_in;
         ee_ff  <= ee_in;
         ev_ff  <= ev_in;
         en_ff  <= en_in;
         eo_ff  <= eo_in;
         g_ff   <= g_in;
         y_ff   <= y_in;
         y2_ff  <= y2_in;
         yb_ff  <= y_ff;
         y3_ff  <= y3_in;
         yc_ff  <= yb_ff;
         ws_ff  <= ws_in;
         mm_ff  <= mm_in;
         os_ff  <= os_in;
      end
   end

endmodule

>>> sv/diode_soft_clip_waveshaper.sv
// Diode-style soft clipper with dry/wet mix. Each item on req_if is one
// signed Q1.23 sample; the matching item on rsp_if is the shaped sample in
// signed Q2.22, produced in the same order. The intensity register (byte
// address 0, tenths of a percent, values above 1000 act as 1000, reset 500)
// sets the mix and the drive; zero passes the sample through unchanged. The
// block takes one item per clock cycle for as long as the result side keeps
// up. An accepted item passes the input register, the queue and the back-end
// pipeline, whose log2 and exp2 units each use thirty multiply stages. A
// stalled result holds the whole back end; the four-entry queue and the input
// register then absorb up to five more items before the input stops.
`timescale 1ns / 1ps

module diode_soft_clip_waveshaper import dscw_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   dscw_req_if.sink                 req_if,
   dscw_rsp_if.source               rsp_if,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   // Configuration register. Writes complete in the access phase; pready is
   // tied high so every transfer finishes without wait states.
   logic [9:0]     intensity_ff, intensity_in;
   logic           csr_write;
   logic           csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_BITS-1:2] == REG_INTENSITY);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;
   assign intensity_in = csr_write ? csr_pwdata[9:0] : intensity_ff;
   assign csr_prdata = csr_hit ? {22'd0, intensity_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         intensity_ff <= INTENSITY_RESET;
      end else begin
         intensity_ff <= intensity_in;
      end
   end

   // Front end: takes the sample, splits off the sign, scales the magnitude
   // to Q.30, clamps the intensity and flags bypass items.
   logic           f_valid;
   logic           f_ready;
   front_item_type f_item;

   dscw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .in_sample (req_if.sample_in),
      .intensity (intensity_ff),
      .out_valid (f_valid),
      .out_item  (f_item),
      .out_ready (f_ready)
   );

   // Queue between the two halves.
   logic           q_valid;
   logic           q_pop;
   front_item_type q_item;

   dscw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_item  (f_item),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_item   (q_item)
   );

   // Back end: the arithmetic pipeline with its own output register.
   dscw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (q_valid),
      .in_item    (q_item),
      .in_pop     (q_pop),
      .out_valid  (rsp_if.valid),
      .out_sample (rsp_if.sample_out),
      .out_ready  (rsp_if.ready)
   );

endmodule

>>> sv/dscw_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dscw_checker import dscw_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SAMPLE_BITS-1:0] rsp_sample,
   input logic                   csr_pready,
   input logic [31:0]            csr_prdata
);

   `DSCW_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `DSCW_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_sample))
   `DSCW_ASSERT_RST(a_reset_idle, clock, reset |=> !rsp_valid)
   `DSCW_ASSERT_RST(a_pready, clock, csr_pready)
   `DSCW_ASSERT(a_prdata_width, clock, reset, csr_prdata[31:10] == 22'd0)

endmodule

bind diode_soft_clip_waveshaper dscw_checker u_dscw_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rsp_sample (rsp_if.sample_out),
   .csr_pready (csr_pready),
   .csr_prdata (csr_prdata)
);

>>> bench/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the diode soft clipper.
// A directed table is sent first. Its rows check the reset intensity, bypass,
// full wet, intensity above 1000 and the extreme samples. After it come about
// 850 random samples, spread over several intensity settings. Every result is
// compared with its table row or with a bit-exact datapath model in this
// module. The intensity register is only written once the pipeline has drained.
module testbench;
   import dscw_pkg::*;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct {
      logic [9:0] intensity;
      sample_type sample;
      bit         known;
      sample_type want;
   } stim_row_type;

   localparam int DRAIN_CYCLES = 100;
   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 850;
   localparam int PHASES       = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dscw_req_if req_if ();
   dscw_rsp_if rsp_if ();

   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [31:0]              csr_pwdata = '0;
   logic [31:0]              csr_prdata;
   logic                     csr_pready;

   diode_soft_clip_waveshaper uut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if.sink),
      .rsp_if      (rsp_if.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Table of 2^(2^-k) in Q.30, built with an integer square root from 2.0.
   logic [63:0] root2_tab [0:EXP_STEPS];

   // Intensity the block currently holds. It is mirrored here on every write.
   logic [9:0] intensity_now = INTENSITY_RESET;

   sample_type shaped_q[$];
   int      errors = 0;
   int      samples_sent = 0;
   int      samples_checked = 0;
   int      quiet_cycles = 0;
   // Once this is set, neither side inserts random idle gaps.
   bit      steady = 1'b0;

   function automatic logic [63:0] int_sqrt(input logic [63:0] n);
      logic [63:0] root;
      logic [63:0] bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // Expected output sample for one input sample at a given intensity.
   function automatic sample_type clip_sample(input sample_type s, input logic [9:0] intensity);
      logic [63:0] full;
      logic [63:0] mag_in;
      logic [63:0] t;
      logic [63:0] a30, w, drive, x, u, lg, frac, ex, mant, p, n, r, v, pw, g;
      logic [63:0] y, y2, y3, ws, m, mag;
      bit          neg;
      full = 64'd1 << SAMPLE_BITS;
      neg = s[SAMPLE_BITS-1];
      mag_in = neg ? full - {40'd0, s} : {40'd0, s};
      t = (intensity > INTENSITY_MAX) ? 64'(INTENSITY_MAX) : 64'(intensity);
      if (t == 0) begin
         // Bypass only changes the format, rounding the halved magnitude up.
         mag = (mag_in + 1) >> 1;
      end else begin
         a30 = mag_in << ISH;
         w = ((t << FB) + 500) / 1000;
         drive = ONE_Q + 4 * w;
         x = (a30 * drive + HALF_Q) >> FB;
         // log2 of 1+x: integer part from the leading bit, fraction by squaring.
         u = ONE_Q + x;
         ex = (u >= (ONE_Q << 2)) ? 2 : (u >= (ONE_Q << 1)) ? 1 : 0;
         mant = u >> ex;
         frac = 0;
         for (int k = 0; k < FB; k++) begin
            mant = (mant * mant) >> FB;
            frac = frac << 1;
            if (mant >= 2 * ONE_Q) begin
               mant = mant >> 1;
               frac = frac | 1;
            end
         end
         lg = (ex << FB) | frac;
         p = (lg * C_0P7 + HALF_Q) >> FB;
         n = (p >> FB) & 3;
         r = p & (ONE_Q - 1);
         // 2^(1-r) as a product of table entries; exactly 2 when r is zero.
         v = ONE_Q - r;
         if (v >= ONE_Q) begin
            pw = 2 * ONE_Q;
         end else begin
            pw = ONE_Q;
            for (int k = 1; k <= EXP_STEPS; k++)
               if ((v >> (FB - k)) & 1) pw = (pw * root2_tab[k] + HALF_Q) >> FB;
         end
         g = (pw + (64'd1 << n)) >> (n + 1);
         y = (x * g + HALF_Q) >> FB;
         y2 = (y * y + HALF_Q) >> FB;
         y3 = (y2 * y + HALF_Q) >> FB;
         ws = (y * C_0P9 + y3 * C_0P1 + HALF_Q) >> FB;
         m = ((ONE_Q - w) * a30 + w * ws + HALF_Q) >> FB;
         mag = (m + (64'd1 << (OSH - 1))) >> OSH;
      end
      return neg ? sample_type'(full - mag) : sample_type'(mag);
   endfunction

   // Two-phase register write; the register takes the value at the access edge.
   task automatic write_intensity(input logic [9:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_ADDR_BITS'({REG_INTENSITY, 2'b00});
      csr_pwdata <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      intensity_now = value;
   endtask

   // Let every outstanding result come back before the register changes.
   task automatic drain_pipeline();
      while (shaped_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Offer one item and hold it until it is taken. The expected result is
   // queued at the edge where the handshake happens. Valid is left high so a
   // following item can go out back to back.
   task automatic send_sample(input sample_type s, input bit known, input sample_type want);
      req_if.valid <= 1'b1;
      req_if.sample_in <= s;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      shaped_q.push_back(known ? want : clip_sample(s, intensity_now));
      samples_sent++;
   endtask

   // Random gap on the input side, now and then.
   task automatic maybe_pause();
      if (!steady && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   function automatic sample_type random_sample();
      case ($urandom_range(0, 5))
         0: return sample_type'($urandom_range(0, 255) - 128);
         1: return sample_type'($urandom_range(0, 65535) - 32768);
         2: return $urandom_range(0, 1) ? sample_type'(24'h7FFFFF - $urandom_range(0, 15))
                                        : sample_type'(24'h800000 + $urandom_range(0, 15));
         default: return sample_type'($urandom);
      endcase
   endfunction

   // Result side: ready drops in random bursts until the steady part.
   initial begin
      rsp_if.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!steady && $urandom_range(0, 7) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
      end
   end

   // Each result is checked against the oldest expected sample.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (shaped_q.size() == 0) begin
            $error("sample_out: no result expected, got %0d", rsp_if.sample_out);
            errors++;
         end else begin
            sample_type want;
            want = shaped_q.pop_front();
            samples_checked++;
            if (rsp_if.sample_out !== want) begin
               $error("sample_out: expected %0d, got %0d", want, rsp_if.sample_out);
               errors++;
            end
         end
      end
   end

   // Watchdog: any handshake on either channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout after %0d cycles without progress", STALL_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      stim_row_type rows[$];
      logic [9:0]  phase_intensity[PHASES];
      int          per_phase;

      req_if.valid = 1'b0;
      req_if.sample_in = '0;

      // Reset intensity is 500: zero stays zero at any intensity.
      rows.push_back('{10'd500, 24'sd0, 1'b1, 24'sd0});
      rows.push_back('{10'd500, 24'sd8388607, 1'b0, 24'sd0});
      rows.push_back('{10'd500, -24'sd8388608, 1'b0, 24'sd0});
      rows.push_back('{10'd500, 24'sd1, 1'b0, 24'sd0});
      rows.push_back('{10'd500, -24'sd1, 1'b0, 24'sd0});
      rows.push_back('{10'd500, 24'sd4194304, 1'b0, 24'sd0});
      // Bypass: the sample comes back in the output format, halved and rounded.
      rows.push_back('{10'd0, 24'sd8388607, 1'b1, 24'sd4194304});
      rows.push_back('{10'd0, -24'sd8388608, 1'b1, -24'sd4194304});
      rows.push_back('{10'd0, 24'sd1, 1'b1, 24'sd1});
      rows.push_back('{10'd0, -24'sd1, 1'b1, -24'sd1});
      rows.push_back('{10'd0, 24'sd0, 1'b1, 24'sd0});
      rows.push_back('{10'd0, 24'sd12345, 1'b1, 24'sd6173});
      // Full wet, then an intensity above 1000 that must act as 1000.
      rows.push_back('{10'd1000, 24'sd8388607, 1'b0, 24'sd0});
      rows.push_back('{10'd1000, -24'sd8388608, 1'b0, 24'sd0});
      rows.push_back('{10'd1000, 24'sd1, 1'b0, 24'sd0});
      rows.push_back('{10'd1000, -24'sd1, 1'b0, 24'sd0});
      rows.push_back('{10'd1000, 24'sd0, 1'b1, 24'sd0});
      rows.push_back('{10'd1023, 24'sd8388607, 1'b0, 24'sd0});
      rows.push_back('{10'd1023, -24'sd8388608, 1'b0, 24'sd0});
      rows.push_back('{10'd1023, -24'sd3000000, 1'b0, 24'sd0});
      // The lightest mix.
      rows.push_back('{10'd1, 24'sd8388607, 1'b0, 24'sd0});
      rows.push_back('{10'd1, -24'sd8388608, 1'b0, 24'sd0});

      root2_tab[0] = 2 * ONE_Q;
      for (int k = 1; k <= EXP_STEPS; k++)
         root2_tab[k] = int_sqrt(root2_tab[k-1] << FB);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         if (rows[i].intensity != intensity_now) begin
            req_if.valid <= 1'b0;
            drain_pipeline();
            write_intensity(rows[i].intensity);
         end
         send_sample(rows[i].sample, rows[i].known, rows[i].want);
         maybe_pause();
      end

      // Random part: the extremes first, then random settings, and a steady
      // final phase at the reset value with no idling on either side.
      phase_intensity[0] = 10'd1000;
      phase_intensity[1] = 10'd0;
      phase_intensity[2] = 10'd1;
      phase_intensity[3] = 10'($urandom_range(1001, 1023));
      phase_intensity[4] = 10'($urandom_range(2, 999));
      phase_intensity[5] = 10'($urandom_range(2, 999));
      phase_intensity[6] = 10'($urandom_range(2, 999));
      phase_intensity[7] = INTENSITY_RESET;
      per_phase = RANDOM_ITEMS / PHASES;
      for (int ph = 0; ph < PHASES; ph++) begin
         req_if.valid <= 1'b0;
         drain_pipeline();
         write_intensity(phase_intensity[ph]);
         if (ph == PHASES - 1) steady = 1'b1;
         for (int i = 0; i < per_phase; i++) begin
            send_sample(random_sample(), 1'b0, '0);
            maybe_pause();
         end
      end
      req_if.valid <= 1'b0;

      drain_pipeline();
      $display("Covered %0d samples (%0d checked) over %0d random intensity phases,",
               samples_sent, samples_checked, PHASES);
      $display("including bypass, full wet, intensities above 1000 and extreme samples.");
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
